[hw/rtl/radix_prefix_number_parser_top_defines.svh]
// assertion macros for the radix prefix number parser
// used by the port checker; no other dependencies
`ifndef RADIX_PREFIX_NUMBER_PARSER_TOP_DEFINES_SVH
`define RADIX_PREFIX_NUMBER_PARSER_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define RPNP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define RPNP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/rpnp_pkg.sv]
// shared types and constants for the radix prefix number parser
// no dependencies
package rpnp_pkg;

    // accumulator and result width
    localparam int unsigned ACC_W = 16;

    // character codes
    localparam logic [7:0] ASC_0  = 8'h30;
    localparam logic [7:0] ASC_9  = 8'h39;
    localparam logic [7:0] ASC_UA = 8'h41;
    localparam logic [7:0] ASC_UF = 8'h46;
    localparam logic [7:0] ASC_LA = 8'h61;
    localparam logic [7:0] ASC_LF = 8'h66;
    localparam logic [7:0] ASC_B  = 8'h62;
    localparam logic [7:0] ASC_H  = 8'h68;
    localparam logic [7:0] ASC_X  = 8'h78;
    localparam logic [7:0] LOWER_OFS = ASC_LA - 8'd10;
    localparam logic [7:0] UPPER_OFS = ASC_UA - 8'd10;

    // character position saturates at two
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_LATER  = 2'd2;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_BIN = 2'd1,
        RADIX_HEX = 2'd2
    } radix_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_item_t;

    typedef struct packed {
        logic [ACC_W-1:0] value;
        logic             parse_error;
    } result_item_t;

    // stage control from the core to the input and output registers
    typedef struct packed {
        logic take;
        logic emit;
    } step_t;

endpackage

[hw/rtl/radix_prefix_number_parser_top.sv]
// top level of the radix prefix number parser
// depends on rpnp_pkg, rpnp_in_reg, rpnp_core, rpnp_out_reg
//
// Usage:
//   char channel: one ASCII character per item (char_code) with last_char
//   set on the final character of a string. A leading 'b' or 'h', or a
//   'b' or 'x' in second place, selects binary or hex; decimal otherwise.
//   result channel: one item per string, on its last character: the value
//   modulo 2^16, or zero with parse_error set if a bad digit was seen.
//   Path: an accepted last character is held in the input register until
//   the result register is free, then its result is written into the result
//   register and shows on result_valid.
//   Throughput: one character per cycle while the result slot is free,
//   including one-character strings; the single update stage sets the rate.
//   Reset clears the parser state and both item valid flags; a string in
//   progress is dropped. When the receiver stalls the result is held;
//   characters that do not end a string keep flowing, and a last character
//   waits in the input register, dropping char_ready, until the slot frees.
module radix_prefix_number_parser_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   char_valid,
    output logic                   char_ready,
    input  rpnp_pkg::char_item_t   char_item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output rpnp_pkg::result_item_t result_item
);

    logic                   held_valid;
    rpnp_pkg::char_item_t   held_item;
    logic                   out_free;
    rpnp_pkg::step_t        step;
    rpnp_pkg::result_item_t result;

    // input register
    rpnp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item),
        .step       (step),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    // parser state and update
    rpnp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .held_item  (held_item),
        .out_free   (out_free),
        .step       (step),
        .result     (result)
    );

    // result register
    rpnp_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .result       (result),
        .out_free     (out_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

endmodule

[hw/rtl/rpnp_in_reg.sv]
// input register of the radix prefix number parser
// depends on rpnp_pkg
module rpnp_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    output logic                char_ready,
    input  rpnp_pkg::char_item_t char_item,
    input  rpnp_pkg::step_t     step,
    output logic                held_valid,
    output rpnp_pkg::char_item_t held_item
);

    logic                 valid_reg;
    logic                 valid_next;
    rpnp_pkg::char_item_t item_reg;

    // slot frees when the core takes the held item
    assign char_ready = !valid_reg || step.take;

    always_comb
    begin
        valid_next = valid_reg;
        if (char_valid && char_ready)
        begin
            valid_next = 1'b1;
        end
        else if (step.take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
        begin
            item_reg <= char_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

[hw/rtl/rpnp_core.sv]
// parser state and per-character update
// depends on rpnp_pkg
module rpnp_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   held_valid,
    input  rpnp_pkg::char_item_t   held_item,
    input  logic                   out_free,
    output rpnp_pkg::step_t        step,
    output rpnp_pkg::result_item_t result
);

    logic [rpnp_pkg::ACC_W-1:0] acc_reg;
    logic [rpnp_pkg::ACC_W-1:0] acc_next;
    rpnp_pkg::radix_t           radix_reg;
    rpnp_pkg::radix_t           radix_next;
    logic [1:0]                 pos_reg;
    logic [1:0]                 pos_next;
    logic                       err_reg;
    logic                       err_next;

    logic [7:0]                 c;
    logic                       is_dec;
    logic                       is_lower_hex;
    logic                       is_upper_hex;
    logic [7:0]                 digit_wide;
    logic [3:0]                 digit;
    logic                       digit_ok;
    logic                       is_prefix;
    rpnp_pkg::radix_t           prefix_radix;
    logic [rpnp_pkg::ACC_W-1:0] acc_scaled;
    logic [rpnp_pkg::ACC_W-1:0] acc_sum;

    assign c = held_item.char_code;

    // item handoff: a last item needs a free result slot
    assign step.take = held_valid && (!held_item.last_char || out_free);
    assign step.emit = step.take && held_item.last_char;

    // digit decode
    always_comb
    begin
        is_dec       = (c >= rpnp_pkg::ASC_0) && (c <= rpnp_pkg::ASC_9);
        is_lower_hex = (c >= rpnp_pkg::ASC_LA) && (c <= rpnp_pkg::ASC_LF);
        is_upper_hex = (c >= rpnp_pkg::ASC_UA) && (c <= rpnp_pkg::ASC_UF);
        if (is_lower_hex)
        begin
            digit_wide = c - rpnp_pkg::LOWER_OFS;
        end
        else if (is_upper_hex)
        begin
            digit_wide = c - rpnp_pkg::UPPER_OFS;
        end
        else
        begin
            digit_wide = c - rpnp_pkg::ASC_0;
        end
        digit = digit_wide[3:0];
    end

    // digit range check and scale by the base
    always_comb
    begin
        unique case (radix_reg)
            rpnp_pkg::RADIX_BIN:
            begin
                digit_ok   = is_dec && (digit < 4'd2);
                acc_scaled = acc_reg << 1;
            end
            rpnp_pkg::RADIX_HEX:
            begin
                digit_ok   = is_dec || is_lower_hex || is_upper_hex;
                acc_scaled = acc_reg << 4;
            end
            default:
            begin
                digit_ok   = is_dec;
                acc_scaled = (acc_reg << 3) + (acc_reg << 1);
            end
        endcase
        acc_sum = acc_scaled + {{(rpnp_pkg::ACC_W-4){1'b0}}, digit};
    end

    // prefix letters while the accumulator is still zero
    always_comb
    begin
        is_prefix    = 1'b0;
        prefix_radix = rpnp_pkg::RADIX_HEX;
        if (acc_reg == '0)
        begin
            if ((pos_reg == rpnp_pkg::POS_FIRST || pos_reg == rpnp_pkg::POS_SECOND)
                && c == rpnp_pkg::ASC_B)
            begin
                is_prefix    = 1'b1;
                prefix_radix = rpnp_pkg::RADIX_BIN;
            end
            else if (pos_reg == rpnp_pkg::POS_FIRST && c == rpnp_pkg::ASC_H)
            begin
                is_prefix = 1'b1;
            end
            else if (pos_reg == rpnp_pkg::POS_SECOND && c == rpnp_pkg::ASC_X)
            begin
                is_prefix = 1'b1;
            end
        end
    end

    // next state; a last item returns the state to its reset values
    always_comb
    begin
        acc_next   = acc_reg;
        radix_next = radix_reg;
        err_next   = err_reg;
        pos_next   = (pos_reg == rpnp_pkg::POS_LATER) ? pos_reg : pos_reg + 2'd1;
        if (!err_reg)
        begin
            if (is_prefix)
            begin
                radix_next = prefix_radix;
            end
            else if (digit_ok)
            begin
                acc_next = acc_sum;
            end
            else
            begin
                err_next = 1'b1;
            end
        end
        if (held_item.last_char)
        begin
            acc_next   = '0;
            radix_next = rpnp_pkg::RADIX_DEC;
            pos_next   = rpnp_pkg::POS_FIRST;
            err_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            radix_reg <= rpnp_pkg::RADIX_DEC;
            pos_reg   <= rpnp_pkg::POS_FIRST;
            err_reg   <= 1'b0;
        end
        else if (step.take)
        begin
            acc_reg   <= acc_next;
            radix_reg <= radix_next;
            pos_reg   <= pos_next;
            err_reg   <= err_next;
        end
    end

    // result of the string ending with this item
    always_comb
    begin
        result.parse_error = err_reg || (!is_prefix && !digit_ok);
        result.value       = (err_reg || (!is_prefix && !digit_ok)) ? '0
                           : (is_prefix ? acc_reg : acc_sum);
    end

endmodule

[hw/rtl/rpnp_out_reg.sv]
// result register of the radix prefix number parser
// depends on rpnp_pkg
module rpnp_out_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rpnp_pkg::step_t        step,
    input  rpnp_pkg::result_item_t result,
    output logic                   out_free,
    output logic                   result_valid,
    input  logic                   result_ready,
    output rpnp_pkg::result_item_t result_item
);

    logic                   valid_reg;
    logic                   valid_next;
    rpnp_pkg::result_item_t item_reg;

    // slot is free when empty or being taken this cycle
    assign out_free = !valid_reg || result_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (step.emit)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (step.emit)
        begin
            item_reg <= result;
        end
    end

    assign result_valid = valid_reg;
    assign result_item  = item_reg;

endmodule

[hw/rtl/rpnp_checker.sv]
// port-level checks for the radix prefix number parser, bound to the top
// depends on rpnp_pkg and radix_prefix_number_parser_top_defines.svh
`include "radix_prefix_number_parser_top_defines.svh"

module rpnp_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   char_valid,
    input logic                   char_ready,
    input rpnp_pkg::char_item_t   char_item,
    input logic                   result_valid,
    input logic                   result_ready,
    input rpnp_pkg::result_item_t result_item
);

    // a stalled result holds
    `RPNP_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result_item), "stalled result item changed")

    // an error result carries zero
    `RPNP_ASSERT_NOW(a_error_zero, clk, rst_n, result_valid && result_item.parse_error, result_item.value == '0, "error result with nonzero value")

    // with the result slot empty the input never stalls
    `RPNP_ASSERT_NOW(a_ready_when_idle, clk, rst_n, !result_valid, char_ready, "char_ready low with empty result slot")

    // a stall on both sides keeps ready low until the receiver drains
    `RPNP_ASSERT_NEXT(a_stall_kept, clk, rst_n, !char_ready && !result_ready, !char_ready || result_ready, "char_ready rose without result drain")

endmodule

bind radix_prefix_number_parser_top rpnp_checker u_rpnp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .char_item    (char_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
);

[tb/sv/radix_prefix_number_parser_top_tb.sv]
// self-checking testbench for the radix prefix number parser top level
// depends on rpnp_pkg and radix_prefix_number_parser_top; drives character items and
// checks each result item against an in-bench parser model
module radix_prefix_number_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 400;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   char_valid = 1'b0;
    logic                   char_ready;
    rpnp_pkg::char_item_t   char_item = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    rpnp_pkg::result_item_t result_item;

    // stimulus and expectation stores
    rpnp_pkg::char_item_t   pending_chars[$];
    rpnp_pkg::result_item_t expected_numbers[$];
    int           pushed_count = 0;
    int           accepted_count = 0;
    int           fail_count = 0;
    int           cycle_count = 0;
    bit           char_taken = 1'b0;

    // idling control
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    bit           hold_req = 1'b0;
    bit           hold_done = 1'b0;
    int           hold_left = 0;

    // parser model state
    logic [rpnp_pkg::ACC_W-1:0] acc_q = '0;
    rpnp_pkg::radix_t           radix_q = rpnp_pkg::RADIX_DEC;
    logic [1:0]                 pos_q = rpnp_pkg::POS_FIRST;
    bit                         err_q = 1'b0;

    radix_prefix_number_parser_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_item    (char_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    function automatic bit idles_now(input int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    // character for a digit value, letters in either case
    function automatic logic [7:0] digit_char(input int v);
        if (v < 10)
            return rpnp_pkg::ASC_0 + 8'(v);
        else if ($urandom_range(1, 0) == 1)
            return rpnp_pkg::LOWER_OFS + 8'(v);
        else
            return rpnp_pkg::UPPER_OFS + 8'(v);
    endfunction

    // advance the model by one character, queueing a result on the last one
    function automatic void parse_expected(input rpnp_pkg::char_item_t it);
        bit                     prefix;
        int                     base;
        int                     digit;
        logic [31:0]            wide;
        rpnp_pkg::result_item_t res;
        prefix = 1'b0;
        if (!err_q)
        begin
            if (acc_q == '0)
            begin
                if ((pos_q == rpnp_pkg::POS_FIRST || pos_q == rpnp_pkg::POS_SECOND)
                    && it.char_code == rpnp_pkg::ASC_B)
                begin
                    radix_q = rpnp_pkg::RADIX_BIN;
                    prefix = 1'b1;
                end
                else if (pos_q == rpnp_pkg::POS_FIRST && it.char_code == rpnp_pkg::ASC_H)
                begin
                    radix_q = rpnp_pkg::RADIX_HEX;
                    prefix = 1'b1;
                end
                else if (pos_q == rpnp_pkg::POS_SECOND && it.char_code == rpnp_pkg::ASC_X)
                begin
                    radix_q = rpnp_pkg::RADIX_HEX;
                    prefix = 1'b1;
                end
            end
            if (!prefix)
            begin
                case (radix_q)
                    rpnp_pkg::RADIX_BIN: base = 2;
                    rpnp_pkg::RADIX_HEX: base = 16;
                    default:             base = 10;
                endcase
                // out-of-range characters never fall below any base
                if (it.char_code < rpnp_pkg::ASC_0)
                    digit = 255;
                else if (it.char_code >= rpnp_pkg::ASC_LA)
                    digit = int'(it.char_code) - int'(rpnp_pkg::LOWER_OFS);
                else if (it.char_code >= rpnp_pkg::ASC_UA)
                    digit = int'(it.char_code) - int'(rpnp_pkg::UPPER_OFS);
                else if (it.char_code <= rpnp_pkg::ASC_9)
                    digit = int'(it.char_code) - int'(rpnp_pkg::ASC_0);
                else
                    digit = int'(it.char_code);
                if (digit < base)
                begin
                    wide = 32'(acc_q) * 32'(base) + 32'(digit);
                    acc_q = wide[rpnp_pkg::ACC_W-1:0];
                end
                else
                    err_q = 1'b1;
            end
        end
        if (pos_q != rpnp_pkg::POS_LATER)
            pos_q = pos_q + 2'd1;
        if (it.last_char)
        begin
            res.value = err_q ? '0 : acc_q;
            res.parse_error = err_q;
            expected_numbers.push_back(res);
            acc_q = '0;
            radix_q = rpnp_pkg::RADIX_DEC;
            pos_q = rpnp_pkg::POS_FIRST;
            err_q = 1'b0;
        end
    endfunction

    function automatic void push_char(input logic [7:0] code, input bit last);
        rpnp_pkg::char_item_t it;
        it.char_code = code;
        it.last_char = last;
        pending_chars.push_back(it);
        pushed_count++;
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], i == s.len() - 1);
    endfunction

    // mostly well-formed numbers with random prefixes, some broken, some noise
    task automatic add_random_strings(input int item_goal);
        logic [7:0] text[$];
        int         made;
        int         shape;
        int         base;
        int         len;
        int         spot;
        made = 0;
        while (made < item_goal)
        begin
            text.delete();
            shape = $urandom_range(99, 0);
            if (shape < 10)
            begin
                len = $urandom_range(6, 1);
                repeat (len) text.push_back(8'($urandom_range(255, 0)));
            end
            else
            begin
                case ($urandom_range(4, 0))
                    0: base = 10;
                    1:
                    begin
                        base = 2;
                        text.push_back(rpnp_pkg::ASC_B);
                    end
                    2:
                    begin
                        base = 16;
                        text.push_back(rpnp_pkg::ASC_H);
                    end
                    3:
                    begin
                        base = 2;
                        text.push_back(rpnp_pkg::ASC_0);
                        text.push_back(rpnp_pkg::ASC_B);
                    end
                    default:
                    begin
                        base = 16;
                        text.push_back(rpnp_pkg::ASC_0);
                        text.push_back(rpnp_pkg::ASC_X);
                    end
                endcase
                // long runs now and then so the accumulator wraps
                len = ($urandom_range(9, 0) == 0) ? $urandom_range(18, 6) : $urandom_range(5, 0);
                if (base == 10 && len == 0)
                    len = 1;
                repeat (len) text.push_back(digit_char($urandom_range(base - 1, 0)));
                if (shape < 25)
                begin
                    spot = $urandom_range(text.size() - 1, 0);
                    text[spot] = ($urandom_range(1, 0) == 1) ? 8'($urandom_range(255, 0))
                                                             : digit_char($urandom_range(35, base));
                end
            end
            for (int i = 0; i < text.size(); i++)
                push_char(text[i], i == text.size() - 1);
            made += text.size();
        end
    endtask

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // reset, released on a falling clock edge
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // character acceptance feeds the model
    always @(posedge clk)
    begin
        char_taken <= rst_n && char_valid && char_ready;
        if (rst_n && char_valid && char_ready)
        begin
            parse_expected(char_item);
            accepted_count++;
        end
    end

    // character driver, fed from the pending queue
    always @(negedge clk)
    begin
        if (rst_n && (!char_valid || char_taken))
        begin
            if (pending_chars.size() != 0 && !idles_now(send_idle_pct))
            begin
                char_valid <= 1'b1;
                char_item <= pending_chars.pop_front();
            end
            else
                char_valid <= 1'b0;
        end
    end

    // receiver stalls, random and the long hold-off
    always @(negedge clk)
    begin
        result_ready <= rst_n && hold_left == 0 && !idles_now(recv_idle_pct);
    end

    // long receiver hold-off counter
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_req && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        rpnp_pkg::result_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_numbers.size() == 0)
            begin
                $error("result item with none expected: value %0d parse_error %0b",
                       result_item.value, result_item.parse_error);
                fail_count++;
            end
            else
            begin
                want = expected_numbers.pop_front();
                if (result_item.value !== want.value)
                begin
                    $error("value: expected %0d, got %0d", want.value, result_item.value);
                    fail_count++;
                end
                if (result_item.parse_error !== want.parse_error)
                begin
                    $error("parse_error: expected %0b, got %0b",
                           want.parse_error, result_item.parse_error);
                    fail_count++;
                end
            end
        end
    end

    // stimulus phases and end of run
    initial
    begin
        send_idle_pct = 14;
        recv_idle_pct = 69;

        // directed strings: prefixes, wrap, bad characters, code extremes
        push_text("0x");
        push_text("b");
        push_text("h");
        push_text("99999");
        push_text("h1b");
        push_char(8'h00, 1'b1);
        push_char(rpnp_pkg::ASC_0 + 8'd7, 1'b0);
        push_char(8'hFF, 1'b1);
        push_text(":");
        push_text("/5");
        push_text("0b1");
        push_text("hfF");
        add_random_strings(PHASE_ITEMS);
        while (accepted_count != pushed_count) @(negedge clk);

        send_idle_pct = 69;
        recv_idle_pct = 14;
        add_random_strings(PHASE_ITEMS);
        while (accepted_count != pushed_count) @(negedge clk);

        // no idling, with one long receiver hold-off to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        add_random_strings(PHASE_ITEMS);
        while (accepted_count != pushed_count) @(negedge clk);
        while (expected_numbers.size() != 0) @(negedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("** radix_prefix_number_parser_top: PASSED **");
        else
            $display("** radix_prefix_number_parser_top: FAILED **");
        $finish;
    end

    // timeout
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** radix_prefix_number_parser_top: FAILED **");
        $finish;
    end

endmodule
